>>> hw/rtl/qbe_pkg.sv
// Shared types, codes and constants for the queue backpressure escalation block.
// No dependencies; used by qbe_assess and queue_backpressure_escalation.
package qbe_pkg;

  localparam int SLOT_W    = 6;
  localparam int DEPTH_W   = 8;
  localparam int STREAK_W  = 8;
  localparam int CNT_W     = 32;
  localparam int ACT_W     = 2;
  localparam int LINKS_DEF = 64;
  localparam int DEPTH_MAX = 255;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;

  // action codes
  localparam logic [ACT_W-1:0] ACT_SEND       = 2'd0;
  localparam logic [ACT_W-1:0] ACT_THROTTLE   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_KEYFRAME   = 2'd2;
  localparam logic [ACT_W-1:0] ACT_DISCONNECT = 2'd3;

  // register indexes
  localparam logic [2:0] REG_POLICY_ENABLE     = 3'd0;
  localparam logic [2:0] REG_HIGH_WATER        = 3'd1;
  localparam logic [2:0] REG_LOW_WATER         = 3'd2;
  localparam logic [2:0] REG_KEYFRAME_STREAK   = 3'd3;
  localparam logic [2:0] REG_DISCONNECT_STREAK = 3'd4;

  typedef struct packed {
    logic                backed;
    logic [STREAK_W-1:0] streak;
    logic [CNT_W-1:0]    dropped;
    logic [CNT_W-1:0]    throttled;
    logic [CNT_W-1:0]    keyframes;
  } entry_t;

  typedef struct packed {
    logic                enable;
    logic [DEPTH_W-1:0]  high_water;
    logic [DEPTH_W-1:0]  low_water;
    logic [STREAK_W-1:0] keyframe_streak;
    logic [STREAK_W-1:0] disconnect_streak;
  } policy_cfg_t;

endpackage

>>> hw/rtl/qbe_assess.sv
// Combinational policy step for one link entry: hysteresis latch, streak and counters.
// Depends on qbe_pkg.
module qbe_assess (
  input  qbe_pkg::policy_cfg_t         cfg,
  input  qbe_pkg::entry_t              cur,
  input  logic                         fresh,
  input  logic [qbe_pkg::DEPTH_W-1:0]  depth,
  output qbe_pkg::entry_t              nxt,
  output logic [qbe_pkg::ACT_W-1:0]    action
);

  localparam logic [15:0] DMAX = 16'(qbe_pkg::DEPTH_MAX);
  localparam logic [qbe_pkg::STREAK_W-1:0] STREAK_ONE = 1;
  localparam logic [qbe_pkg::CNT_W:0]      CNT_ONE    = 1;

  logic [qbe_pkg::DEPTH_W-1:0] depth_c;
  qbe_pkg::entry_t             e;
  logic [qbe_pkg::CNT_W:0]     drop_sum;
  logic [qbe_pkg::CNT_W:0]     thr_sum;
  logic [qbe_pkg::CNT_W:0]     kf_sum;

  always_comb begin
    depth_c = (16'(depth) > DMAX) ? DMAX[qbe_pkg::DEPTH_W-1:0] : depth;
  end

  always_comb begin
    e        = fresh ? '0 : cur;
    action   = qbe_pkg::ACT_SEND;
    drop_sum = '0;
    thr_sum  = '0;
    kf_sum   = '0;
    if (cfg.enable) begin
      if (!e.backed && depth_c >= cfg.high_water) begin
        e.backed = 1'b1;
        e.streak = '0;
      end else if (e.backed && depth_c <= cfg.low_water) begin
        e.backed = 1'b0;
        e.streak = '0;
      end
      if (e.backed) begin
        if (e.streak != '1) begin
          e.streak = e.streak + STREAK_ONE;
        end
        if (e.streak >= cfg.disconnect_streak) begin
          action = qbe_pkg::ACT_DISCONNECT;
        end else if (e.streak == cfg.keyframe_streak) begin
          drop_sum    = {1'b0, e.dropped} + (qbe_pkg::CNT_W + 1)'(depth_c);
          kf_sum      = {1'b0, e.keyframes} + CNT_ONE;
          // saturate on carry out
          e.dropped   = drop_sum[qbe_pkg::CNT_W] ? '1 : drop_sum[qbe_pkg::CNT_W-1:0];
          e.keyframes = kf_sum[qbe_pkg::CNT_W] ? '1 : kf_sum[qbe_pkg::CNT_W-1:0];
          action      = qbe_pkg::ACT_KEYFRAME;
        end else begin
          thr_sum     = {1'b0, e.throttled} + CNT_ONE;
          e.throttled = thr_sum[qbe_pkg::CNT_W] ? '1 : thr_sum[qbe_pkg::CNT_W-1:0];
          action      = qbe_pkg::ACT_THROTTLE;
        end
      end
    end
    nxt = e;
  end

endmodule

>>> hw/rtl/queue_backpressure_escalation.sv
// Per-link backpressure escalation: watermark latch, streak and saturating counters.
// Depends on qbe_pkg and qbe_assess.
//
// Usage: each input item names a link slot, that link's live queue depth and a
// fresh flag (new client, clears the slot first). One result item comes back per
// input item, in order: the action (send, throttle, drop backlog + keyframe,
// disconnect), the latch and streak after the step and the slot's three counters.
// Items move on valid/stall; an item is taken at an edge with valid high and
// stall low. It passes the assessment stage, then the output register to
// out_valid; unless the receiver stalls, throughput is one item per cycle, set by
// the single read-modify-write of the per-link entry (registered memory read, one
// assessment stage, write back with bypass to a following item for the same slot).
// When the receiver stalls, the result waits in the output register, one more
// item waits in the assessment stage, and then in_stall rises.
// Reset clears the registers to their reset values and marks every slot entry
// invalid (reads as zero); no clearing pass is needed. Slots at or above LINKS
// return an all-zero result and change nothing. Configuration goes over an
// APB-style port at byte address 4*index and should only be written while idle.
module queue_backpressure_escalation #(
  parameter int LINKS = qbe_pkg::LINKS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [qbe_pkg::SLOT_W-1:0]      in_link_slot,
  input  logic [qbe_pkg::DEPTH_W-1:0]     in_queue_depth,
  input  logic                            in_fresh,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [qbe_pkg::ACT_W-1:0]       out_action,
  output logic                            out_is_backed_up,
  output logic [qbe_pkg::STREAK_W-1:0]    out_streak,
  output logic [qbe_pkg::CNT_W-1:0]       out_dropped_total,
  output logic [qbe_pkg::CNT_W-1:0]       out_throttled_total,
  output logic [qbe_pkg::CNT_W-1:0]       out_keyframe_total,
  // configuration port
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [qbe_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [qbe_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [qbe_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);

  localparam int IW = (LINKS > 1) ? $clog2(LINKS) : 1;
  localparam int SW = qbe_pkg::SLOT_W;

  // ---------------- configuration ----------------
  qbe_pkg::policy_cfg_t cfg_r;
  logic [2:0]           reg_idx;
  logic                 cfg_wr;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable            <= 1'b0;
      cfg_r.high_water        <= 8'd8;
      cfg_r.low_water         <= 8'd0;
      cfg_r.keyframe_streak   <= 8'd4;
      cfg_r.disconnect_streak <= 8'd16;
    end else if (cfg_wr) begin
      case (reg_idx)
        qbe_pkg::REG_POLICY_ENABLE:     cfg_r.enable            <= cfg_pwdata[0];
        qbe_pkg::REG_HIGH_WATER:        cfg_r.high_water        <= cfg_pwdata[7:0];
        qbe_pkg::REG_LOW_WATER:         cfg_r.low_water         <= cfg_pwdata[7:0];
        qbe_pkg::REG_KEYFRAME_STREAK:   cfg_r.keyframe_streak   <= cfg_pwdata[7:0];
        qbe_pkg::REG_DISCONNECT_STREAK: cfg_r.disconnect_streak <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      qbe_pkg::REG_POLICY_ENABLE:     cfg_prdata = 32'(cfg_r.enable);
      qbe_pkg::REG_HIGH_WATER:        cfg_prdata = 32'(cfg_r.high_water);
      qbe_pkg::REG_LOW_WATER:         cfg_prdata = 32'(cfg_r.low_water);
      qbe_pkg::REG_KEYFRAME_STREAK:   cfg_prdata = 32'(cfg_r.keyframe_streak);
      qbe_pkg::REG_DISCONNECT_STREAK: cfg_prdata = 32'(cfg_r.disconnect_streak);
      default:                        cfg_prdata = '0;
    endcase
  end

  // ---------------- handshake ----------------
  logic s1_v_r;
  logic out_valid_r;
  logic adv;
  logic in_acc;

  assign adv      = s1_v_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_v_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  // ---------------- slot index ----------------
  logic [SW+IW-1:0] slot_ext;
  logic [IW-1:0]    rd_idx;
  logic             rd_in_range;

  assign slot_ext    = {{IW{1'b0}}, in_link_slot};
  assign rd_idx      = slot_ext[IW-1:0];
  assign rd_in_range = 32'(in_link_slot) < 32'(LINKS);

  // ---------------- per-link store ----------------
  qbe_pkg::entry_t mem [LINKS];
  logic [LINKS-1:0] vld_r;

  qbe_pkg::entry_t memq_r;
  logic            vldq_r;
  logic [IW-1:0]   s1_idx_r;
  logic            s1_in_range_r;
  logic [qbe_pkg::DEPTH_W-1:0] s1_depth_r;
  logic            s1_fresh_r;
  logic            byp_r;
  qbe_pkg::entry_t byp_data_r;

  qbe_pkg::entry_t cur;
  qbe_pkg::entry_t nxt;
  logic [qbe_pkg::ACT_W-1:0] act;
  logic            wr_en;

  assign wr_en = adv && s1_in_range_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s1_idx_r] <= nxt;
    end
    if (in_acc) begin
      memq_r <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[s1_idx_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      byp_r  <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_v_r <= 1'b1;
        // the read above misses a write to the same slot at this edge
        byp_r  <= wr_en && (s1_idx_r == rd_idx) && rd_in_range;
      end else if (adv) begin
        s1_v_r <= 1'b0;
        byp_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      vldq_r        <= vld_r[rd_idx];
      s1_idx_r      <= rd_idx;
      s1_in_range_r <= rd_in_range;
      s1_depth_r    <= in_queue_depth;
      s1_fresh_r    <= in_fresh;
      byp_data_r    <= nxt;
    end
  end

  always_comb begin
    if (byp_r) begin
      cur = byp_data_r;
    end else if (vldq_r) begin
      cur = memq_r;
    end else begin
      cur = '0;
    end
  end

  qbe_assess u_assess (
    .cfg    (cfg_r),
    .cur    (cur),
    .fresh  (s1_fresh_r),
    .depth  (s1_depth_r),
    .nxt    (nxt),
    .action (act)
  );

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (s1_in_range_r) begin
        out_action          <= act;
        out_is_backed_up    <= nxt.backed;
        out_streak          <= nxt.streak;
        out_dropped_total   <= nxt.dropped;
        out_throttled_total <= nxt.throttled;
        out_keyframe_total  <= nxt.keyframes;
      end else begin
        out_action          <= qbe_pkg::ACT_SEND;
        out_is_backed_up    <= 1'b0;
        out_streak          <= '0;
        out_dropped_total   <= '0;
        out_throttled_total <= '0;
        out_keyframe_total  <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;

  // ---------------- assertions ----------------
  a_bypass_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    byp_r |-> s1_v_r)
    else $error("bypass flagged with no item in the assessment stage");

  a_throttle_backed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_action != qbe_pkg::ACT_SEND) |-> out_is_backed_up)
    else $error("escalation reported on a link that is not backed up");

  a_disconnect_streak: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_action == qbe_pkg::ACT_DISCONNECT) |->
      (out_streak >= cfg_r.disconnect_streak))
    else $error("disconnect below the deadline");

  a_disabled_sends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !cfg_r.enable && $stable(cfg_r.enable)) |->
      (out_action == qbe_pkg::ACT_SEND))
    else $error("non-send action with the policy disabled");

endmodule
